@@ sv/dll_pkg.sv @@
// Shared types and constants for the doubly linked list engine.
package dll_pkg;
   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [2:0] FUNC_READ = 3'd0;
   localparam logic [2:0] FUNC_INS_HEAD = 3'd1;
   localparam logic [2:0] FUNC_INS_TAIL = 3'd2;
   localparam logic [2:0] FUNC_INS_AFTER = 3'd3;
   localparam logic [2:0] FUNC_DEL_HEAD = 3'd4;
   localparam logic [2:0] FUNC_DEL_TAIL = 3'd5;
   localparam logic [2:0] FUNC_DEL_KEY = 3'd6;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_INS_A,
      ST_INS_B,
      ST_DEL_A,
      ST_DEL_B,
      ST_REPORT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic walk_start;
      logic walk_read;
      logic walk_advance;
      logic ins_a;
      logic ins_b;
      logic del_a;
      logic del_b;
      logic emit_elem;
      logic emit_done;
      logic [1:0] status;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [2:0] func;
      logic empty;
      logic full;
      logic walk_null;
      logic walk_hit;
      logic walk_final;
      logic out_busy;
   } sts_type;
endpackage

@@ sv/dll_datapath.sv @@
// Node pool, list pointers, walker and output register of the list engine.
module dll_datapath #(
   parameter int CAPACITY = dll_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEFAULT,
   localparam int PW = $clog2(CAPACITY + 1),
   localparam int IW = $clog2(CAPACITY)
) (
   input  logic clock,
   input  logic reset,
   input  dll_pkg::cmd_type cmd,
   output dll_pkg::sts_type sts,
   input  logic [2:0] req_func,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_key,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_element,
   output logic rsp_last,
   output logic [4:0] rsp_length
);
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
   logic [PW-1:0] next_mem [CAPACITY];
   logic [PW-1:0] prev_mem [CAPACITY];

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0] func_ff;
   logic [VALUE_WIDTH-1:0] val_ff, key_ff;
   logic [PW-1:0] cur_ff, cur_in;      // node being walked
   logic [CW-1:0] steps_ff, steps_in;
   logic [VALUE_WIDTH-1:0] rd_val_ff;
   logic [PW-1:0] rd_next_ff, rd_prev_ff;
   logic [PW-1:0] q_ff;                // neighbor read for insert
   logic [IW-1:0] alloc_idx;
   logic [PW-1:0] tgt_ff;              // insert predecessor or delete target

   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [31:0] rsp_element_ff;
   logic rsp_last_ff;
   logic [4:0] rsp_length_ff;

   function automatic logic [VALUE_WIDTH-1:0] cut(input logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[VALUE_WIDTH-1:0];
   endfunction

   always_comb begin
      alloc_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) alloc_idx = IW'(i);
      end
   end

   // Walk and neighbor reads come from registered memory read ports.
   always_ff @(posedge clock) begin
      if (cmd.walk_read) begin
         rd_val_ff <= value_mem[cur_ff[IW-1:0]];
         rd_next_ff <= next_mem[cur_ff[IW-1:0]];
         rd_prev_ff <= prev_mem[cur_ff[IW-1:0]];
      end
      if (cmd.del_a) begin
         rd_next_ff <= next_mem[tgt_ff[IW-1:0]];
         rd_prev_ff <= prev_mem[tgt_ff[IW-1:0]];
      end
      if (cmd.ins_a) begin
         q_ff <= (tgt_ff == NIL) ? head_ff : next_mem[tgt_ff[IW-1:0]];
      end
   end

   // Insert writes the new node and patches its neighbors; delete links the target's neighbors.
   always_ff @(posedge clock) begin
      if (cmd.ins_b) begin
         value_mem[alloc_idx] <= val_ff;
         prev_mem[alloc_idx] <= tgt_ff;
         next_mem[alloc_idx] <= q_ff;
         if (tgt_ff != NIL) next_mem[tgt_ff[IW-1:0]] <= PW'(alloc_idx);
         if (q_ff != NIL) prev_mem[q_ff[IW-1:0]] <= PW'(alloc_idx);
      end
      if (cmd.del_b) begin
         if (rd_prev_ff != NIL) next_mem[rd_prev_ff[IW-1:0]] <= rd_next_ff;
         if (rd_next_ff != NIL) prev_mem[rd_next_ff[IW-1:0]] <= rd_prev_ff;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      free_in = free_ff;
      count_in = count_ff;
      cur_in = cur_ff;
      steps_in = steps_ff;
      if (cmd.walk_start) begin
         cur_in = head_ff;
         steps_in = '0;
      end
      if (cmd.walk_advance) begin
         cur_in = rd_next_ff;
         steps_in = steps_ff + 1'b1;
      end
      if (cmd.ins_b) begin
         if (tgt_ff == NIL) head_in = PW'(alloc_idx);
         if (q_ff == NIL) tail_in = PW'(alloc_idx);
         free_in[alloc_idx] = 1'b0;
         count_in = count_ff + 1'b1;
      end
      if (cmd.del_b) begin
         if (rd_prev_ff == NIL) head_in = rd_next_ff;
         if (rd_next_ff == NIL) tail_in = rd_prev_ff;
         free_in[tgt_ff[IW-1:0]] = 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL;
         tail_ff <= NIL;
         free_ff <= '1;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_ff <= free_in;
         count_ff <= count_in;
         if (cmd.emit_elem || cmd.emit_done) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      steps_ff <= steps_in;
      if (cmd.capture) begin
         func_ff <= req_func;
         val_ff <= cut(req_value);
         key_ff <= cut(req_key);
      end
      // Predecessor for inserts, target for deletes.
      if (cmd.walk_advance && rd_val_ff == key_ff) tgt_ff <= cur_ff;
      if (cmd.capture) begin
         unique case (req_func)
            dll_pkg::FUNC_INS_HEAD: tgt_ff <= NIL;
            dll_pkg::FUNC_INS_TAIL: tgt_ff <= tail_ff;
            dll_pkg::FUNC_INS_AFTER: tgt_ff <= NIL;
            dll_pkg::FUNC_DEL_HEAD: tgt_ff <= head_ff;
            dll_pkg::FUNC_DEL_TAIL: tgt_ff <= tail_ff;
            default: tgt_ff <= NIL;
         endcase
      end
      if (cmd.emit_elem) begin
         rsp_status_ff <= dll_pkg::STATUS_OK;
         rsp_element_ff <= 32'(rd_val_ff);
         rsp_last_ff <= sts.walk_final;
         rsp_length_ff <= 5'(count_ff);
      end
      if (cmd.emit_done) begin
         rsp_status_ff <= cmd.status;
         rsp_element_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_length_ff <= 5'(count_ff);
      end
   end

   always_comb begin
      sts.func = func_ff;
      sts.empty = (count_ff == '0) || (head_ff == NIL);
      sts.full = (count_ff >= CW'(CAPACITY));
      sts.walk_null = (cur_ff == NIL) || (steps_ff >= CW'(CAPACITY));
      sts.walk_hit = (rd_val_ff == key_ff);
      sts.walk_final = (rd_next_ff == NIL) || (steps_ff + 1'b1 >= CW'(CAPACITY));
      sts.out_busy = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_length = rsp_length_ff;

`ifndef SYNTHESIS
   a_count_free: assert property (@(posedge clock) disable iff (reset)
      $countones(~free_ff) == int'(count_ff))
      else $error("element count disagrees with free map");
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == NIL && tail_ff == NIL))
      else $error("empty list with live pointers");
   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_elem && cmd.emit_done))
      else $error("two results in one cycle");
`endif
endmodule

@@ sv/dll_control.sv @@
// Controller state machine of the list engine.
module dll_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic rsp_stall,
   input  dll_pkg::sts_type sts,
   output dll_pkg::cmd_type cmd
);
   dll_pkg::state_type state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic out_free;

   assign out_free = !sts.out_busy || !rsp_stall;
   assign req_stall = (state_ff != dll_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         dll_pkg::ST_IDLE: if (req_valid) state_in = dll_pkg::ST_DISPATCH;
         dll_pkg::ST_DISPATCH: begin
            status_in = dll_pkg::STATUS_OK;
            state_in = dll_pkg::ST_IDLE;
            unique case (sts.func) inside
               dll_pkg::FUNC_READ: begin
                  if (sts.empty) begin
                     status_in = dll_pkg::STATUS_EMPTY;
                     state_in = dll_pkg::ST_REPORT;
                  end else state_in = dll_pkg::ST_WALK_RD;
               end
               dll_pkg::FUNC_INS_HEAD, dll_pkg::FUNC_INS_TAIL: begin
                  if (sts.full) begin
                     status_in = dll_pkg::STATUS_FULL;
                     state_in = dll_pkg::ST_REPORT;
                  end else state_in = dll_pkg::ST_INS_A;
               end
               dll_pkg::FUNC_INS_AFTER: begin
                  if (sts.full) begin
                     status_in = dll_pkg::STATUS_FULL;
                     state_in = dll_pkg::ST_REPORT;
                  end else if (sts.empty) state_in = dll_pkg::ST_INS_A;
                  else state_in = dll_pkg::ST_WALK_RD;
               end
               dll_pkg::FUNC_DEL_HEAD, dll_pkg::FUNC_DEL_TAIL,
               dll_pkg::FUNC_DEL_KEY: begin
                  if (sts.empty) begin
                     status_in = dll_pkg::STATUS_EMPTY;
                     state_in = dll_pkg::ST_REPORT;
                  end else if (sts.func == dll_pkg::FUNC_DEL_KEY)
                     state_in = dll_pkg::ST_WALK_RD;
                  else state_in = dll_pkg::ST_DEL_A;
               end
               default: state_in = dll_pkg::ST_IDLE;
            endcase
         end
         dll_pkg::ST_WALK_RD: begin
            if (sts.walk_null) begin
               status_in = dll_pkg::STATUS_NOT_FOUND;
               state_in = dll_pkg::ST_REPORT;
            end else state_in = dll_pkg::ST_WALK_CHK;
         end
         dll_pkg::ST_WALK_CHK: begin
            if (sts.func == dll_pkg::FUNC_READ) begin
               if (out_free) state_in = sts.walk_final ? dll_pkg::ST_IDLE
                                                       : dll_pkg::ST_WALK_RD;
            end else if (sts.walk_hit) begin
               state_in = (sts.func == dll_pkg::FUNC_INS_AFTER) ? dll_pkg::ST_INS_A
                                                                : dll_pkg::ST_DEL_A;
            end else state_in = dll_pkg::ST_WALK_RD;
         end
         dll_pkg::ST_INS_A: state_in = dll_pkg::ST_INS_B;
         dll_pkg::ST_INS_B: state_in = dll_pkg::ST_REPORT;
         dll_pkg::ST_DEL_A: state_in = dll_pkg::ST_DEL_B;
         dll_pkg::ST_DEL_B: state_in = dll_pkg::ST_REPORT;
         dll_pkg::ST_REPORT: if (out_free) state_in = dll_pkg::ST_IDLE;
         default: state_in = dll_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         dll_pkg::ST_IDLE: cmd.capture = req_valid;
         dll_pkg::ST_DISPATCH: cmd.walk_start = 1'b1;
         dll_pkg::ST_WALK_RD: cmd.walk_read = !sts.walk_null;
         dll_pkg::ST_WALK_CHK: begin
            if (sts.func == dll_pkg::FUNC_READ) begin
               cmd.emit_elem = out_free;
               cmd.walk_advance = out_free;
            end else begin
               // Advance on a hit too: it latches the matching node.
               cmd.walk_advance = 1'b1;
            end
         end
         dll_pkg::ST_INS_A: cmd.ins_a = 1'b1;
         dll_pkg::ST_INS_B: cmd.ins_b = 1'b1;
         dll_pkg::ST_DEL_A: cmd.del_a = 1'b1;
         dll_pkg::ST_DEL_B: cmd.del_b = 1'b1;
         dll_pkg::ST_REPORT: cmd.emit_done = out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dll_pkg::ST_IDLE;
         status_ff <= dll_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end

`ifndef SYNTHESIS
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ins_a, cmd.ins_b, cmd.del_a, cmd.del_b, cmd.emit_elem}))
      else $error("overlapping datapath commands");
   a_no_emit_stalled: assert property (@(posedge clock) disable iff (reset)
      (sts.out_busy && rsp_stall) |-> !(cmd.emit_elem || cmd.emit_done))
      else $error("result overwritten while stalled");
   a_ins_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_a |=> cmd.ins_b)
      else $error("insert sequence broken");
`endif
endmodule

@@ sv/doubly_linked_list_engine_core.sv @@
// Top level of the doubly linked list engine.
// One request item is taken at a time; req_stall stays high until its last
// result item has been loaded into the output register. Read-out and the key
// searches walk the list node by node through the node pool's registered
// read port; while a full output register is stalled, read-out or the final
// report waits. Read-out gives one item per node, head first, last set on the
// tail; every other request gives a single item with element zero. Function
// code seven is dropped with no result. No clearing pass is needed after reset.
module doubly_linked_list_engine_core #(
   parameter int CAPACITY = dll_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_func,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_key,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_element,
   output logic rsp_last,
   output logic [4:0] rsp_length
);
   dll_pkg::cmd_type cmd;
   dll_pkg::sts_type sts;

   // Sequence each request.
   dll_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   // Hold the pool, pointers and the result register.
   dll_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_func), .req_value(req_value), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_element(rsp_element), .rsp_last(rsp_last), .rsp_length(rsp_length)
   );
endmodule

@@ verif/dll_checker.sv @@
// Checker for the linked list engine: tracks accepted request items, predicts responses, compares.
`timescale 1ns / 1ps
module dll_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [2:0] req_func,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_key,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [1:0] rsp_status,
   input  logic signed [31:0] rsp_element,
   input  logic rsp_last,
   input  logic [4:0] rsp_length,
   output int   fail_count,
   output int   pending
);
   localparam int CAP = dll_pkg::CAPACITY_DEFAULT;
   localparam logic [4:0] NIL = 5'(CAP);

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] element;
      logic last;
      logic [4:0] length;
   } rsp_item_type;

   rsp_item_type expected_rsp[$];
   logic [31:0] pool_value[CAP];
   logic [4:0] pool_next[CAP];
   logic [4:0] pool_prev[CAP];
   logic [4:0] head, tail;
   logic [CAP-1:0] free_slots;
   int count;

   assign pending = expected_rsp.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void push_rsp(input logic [1:0] st, input logic [31:0] el,
                                    input logic lst);
      rsp_item_type r;
      r.status = st; r.element = el; r.last = lst; r.length = 5'(count);
      expected_rsp.push_back(r);
   endfunction

   function automatic logic [4:0] find_node(input logic [31:0] k);
      logic [4:0] t;
      t = head;
      for (int s = 0; s < CAP && t != NIL; s++) begin
         if (pool_value[t] == k) return t;
         t = pool_next[t];
      end
      return NIL;
   endfunction

   // Link node n after p, or at the head when p is null.
   function automatic void link_node(input logic [4:0] n, input logic [4:0] p,
                                     input logic [31:0] v);
      logic [4:0] q;
      q = (p != NIL) ? pool_next[p] : head;
      pool_value[n] = v;
      pool_prev[n] = p;
      pool_next[n] = q;
      if (p != NIL) pool_next[p] = n; else head = n;
      if (q != NIL) pool_prev[q] = n; else tail = n;
   endfunction

   function automatic logic [4:0] take_slot();
      for (int i = 0; i < CAP; i++)
         if (free_slots[i]) begin
            free_slots[i] = 1'b0;
            count++;
            return 5'(i);
         end
      return NIL;
   endfunction

   function automatic void unlink(input logic [4:0] n);
      logic [4:0] p, q;
      p = pool_prev[n];
      q = pool_next[n];
      if (p != NIL) pool_next[p] = q; else head = q;
      if (q != NIL) pool_prev[q] = p; else tail = p;
      free_slots[n] = 1'b1;
      count--;
   endfunction

   function automatic void predict(input logic [2:0] f, input logic [31:0] v,
                                   input logic [31:0] k);
      logic [1:0] st;
      logic [4:0] n, p, t;
      st = dll_pkg::STATUS_OK;
      case (f) inside
         dll_pkg::FUNC_READ: begin
            if (count == 0) begin
               push_rsp(dll_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               t = head;
               for (int i = 0; i < CAP && t != NIL; i++) begin
                  push_rsp(dll_pkg::STATUS_OK, pool_value[t],
                           pool_next[t] == NIL || i + 1 >= CAP);
                  t = pool_next[t];
               end
            end
            return;
         end
         dll_pkg::FUNC_INS_HEAD, dll_pkg::FUNC_INS_TAIL, dll_pkg::FUNC_INS_AFTER: begin
            if (count >= CAP) begin
               st = dll_pkg::STATUS_FULL;
            end else begin
               p = NIL;
               if (f == dll_pkg::FUNC_INS_TAIL) p = tail;
               else if (f == dll_pkg::FUNC_INS_AFTER && count != 0) begin
                  p = find_node(k);
                  if (p == NIL) st = dll_pkg::STATUS_NOT_FOUND;
               end
               if (st == dll_pkg::STATUS_OK) begin
                  n = take_slot();
                  link_node(n, p, v);
               end
            end
         end
         dll_pkg::FUNC_DEL_HEAD, dll_pkg::FUNC_DEL_TAIL, dll_pkg::FUNC_DEL_KEY: begin
            if (count == 0) begin
               st = dll_pkg::STATUS_EMPTY;
            end else begin
               n = (f == dll_pkg::FUNC_DEL_HEAD) ? head :
                   (f == dll_pkg::FUNC_DEL_TAIL) ? tail : find_node(k);
               if (n != NIL) unlink(n); else st = dll_pkg::STATUS_NOT_FOUND;
            end
         end
         default: return;
      endcase
      push_rsp(st, '0, 1'b1);
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         expected_rsp.delete();
         head = NIL;
         tail = NIL;
         free_slots = '1;
         count = 0;
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) predict(req_func, req_value, req_key);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report("response item with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status)
                  report($sformatf("status %0d want %0d", rsp_status, want.status));
               if (rsp_element !== want.element)
                  report($sformatf("element %0d want %0d", rsp_element,
                                   $signed(want.element)));
               if (rsp_last !== want.last)
                  report($sformatf("last %0b want %0b", rsp_last, want.last));
               if (rsp_length !== want.length)
                  report($sformatf("length %0d want %0d", rsp_length, want.length));
            end
         end
      end
   end
endmodule

@@ verif/testbench.sv @@
// Top of the linked list engine testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_func = dll_pkg::FUNC_READ;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_element;
   logic rsp_last;
   logic [4:0] rsp_length;
   int fail_count;
   int pending;
   int cycle_count = 0;
   bit calm = 1'b0;       // stretch with no idling on either side
   bit hold_rsp = 1'b0;   // long receiver hold-off to fill the block
   logic [31:0] used_values[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   doubly_linked_list_engine_core dut (.*);

   dll_checker check (.*);

   // Stall the response side about 30% of the time, or solidly during a hold-off.
   always @(posedge clock)
      rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 30);

   // Bound the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Drive one request item and hold it until accepted; valid stays up into
   // the next item unless an idle cycle comes first.
   task automatic send(input logic [2:0] f, input logic [31:0] v, input logic [31:0] k);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_value <= v;
      req_key <= k;
      used_values.push_back(v);
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for one cycle.
   task automatic idle_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Mostly values sent earlier, sometimes random ones.
   function automatic logic [31:0] pick_key();
      if (used_values.size() != 0 && $urandom_range(99) < 75)
         return used_values[$urandom_range(used_values.size() - 1)];
      return $urandom;
   endfunction

   initial begin
      logic [2:0] f;
      int drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extremes, keyed ops, func seven, fill to full.
      send(dll_pkg::FUNC_READ, '0, '0);
      send(dll_pkg::FUNC_DEL_HEAD, '0, '0);
      send(dll_pkg::FUNC_DEL_TAIL, '0, '0);
      send(dll_pkg::FUNC_DEL_KEY, '0, 32'h1);
      send(dll_pkg::FUNC_INS_AFTER, 32'h8000_0000, 32'h55);
      send(dll_pkg::FUNC_INS_HEAD, 32'h7fff_ffff, '0);
      send(dll_pkg::FUNC_INS_TAIL, 32'hffff_ffff, '0);
      send(dll_pkg::FUNC_INS_AFTER, 32'h0, 32'h7fff_ffff);
      send(dll_pkg::FUNC_INS_AFTER, 32'h1234, 32'h2222);
      send(dll_pkg::FUNC_DEL_KEY, '0, 32'h3333);
      send(dll_pkg::FUNC_UNUSED, 32'hdead_beef, '0);
      send(dll_pkg::FUNC_READ, '0, '0);
      send(dll_pkg::FUNC_DEL_KEY, '0, 32'h0);
      send(dll_pkg::FUNC_DEL_HEAD, '0, '0);
      send(dll_pkg::FUNC_DEL_TAIL, '0, '0);
      send(dll_pkg::FUNC_READ, '0, '0);
      idle_req();

      // Fill the pool while the receiver holds off, so the block backs up.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 18; i++) send(dll_pkg::FUNC_INS_TAIL, $urandom, '0);
            idle_req();
         end
      join
      send(dll_pkg::FUNC_INS_AFTER, 32'h42, pick_key());
      send(dll_pkg::FUNC_READ, '0, '0);

      // Random: mix weighted to keep the list mid-sized and keys hitting.
      for (int i = 0; i < 194; i++) begin
         calm = (i >= 100 && i < 140);
         case ($urandom_range(9)) inside
            0, 1: f = dll_pkg::FUNC_READ;
            2: f = dll_pkg::FUNC_INS_HEAD;
            3: f = dll_pkg::FUNC_INS_TAIL;
            4: f = dll_pkg::FUNC_INS_AFTER;
            5: f = dll_pkg::FUNC_DEL_HEAD;
            6: f = dll_pkg::FUNC_DEL_TAIL;
            7, 8: f = dll_pkg::FUNC_DEL_KEY;
            default: f = ($urandom_range(3) == 0) ? dll_pkg::FUNC_UNUSED
                                                  : dll_pkg::FUNC_INS_TAIL;
         endcase
         send(f, any_word(), pick_key());
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      drain = 0;
      while (pending != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

@@ sim.f @@
sv/dll_pkg.sv
sv/dll_datapath.sv
sv/dll_control.sv
sv/doubly_linked_list_engine_core.sv
verif/dll_checker.sv
verif/testbench.sv
